FILE: hdl/ssgr_pkg.sv
// Shared types, constants and helper functions for the seven-segment glyph rasterizer.
`default_nettype none

package ssgr_pkg;

  localparam int MAX_GLYPH_SIZE = 128;
  localparam int SIZE_W         = 8;
  localparam int COORD_W        = 10;
  localparam int BPR_W          = 5;

  localparam logic [SIZE_W-1:0] GLYPH_SIZE_RST = 8'd48;

  // Register byte addresses (paddr[2] picks the register word).
  localparam logic REG_GLYPH_SIZE = 1'b0;

  // Division by 12 and 6 via reciprocal 171/2048, exact for 0..255.
  localparam logic [15:0] RECIP_12 = 16'd171;

  localparam logic [7:0] SEG_A  = 8'h01;
  localparam logic [7:0] SEG_B  = 8'h02;
  localparam logic [7:0] SEG_C  = 8'h04;
  localparam logic [7:0] SEG_D  = 8'h08;
  localparam logic [7:0] SEG_E  = 8'h10;
  localparam logic [7:0] SEG_F  = 8'h20;
  localparam logic [7:0] SEG_G1 = 8'h40;
  localparam logic [7:0] SEG_G2 = 8'h80;

  localparam logic [7:0] DIGIT_SEGS [16] = '{
    SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F,
    SEG_B | SEG_C,
    SEG_A | SEG_B | SEG_D | SEG_E | SEG_G1,
    SEG_A | SEG_B | SEG_C | SEG_D | SEG_G1,
    SEG_B | SEG_C | SEG_F | SEG_G1,
    SEG_A | SEG_C | SEG_D | SEG_F | SEG_G1,
    SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G1,
    SEG_A | SEG_B | SEG_C,
    SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G1,
    SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G1,
    SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G1,
    SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G1,
    SEG_A | SEG_D | SEG_E | SEG_F,
    SEG_B | SEG_C | SEG_D | SEG_E | SEG_G1,
    SEG_A | SEG_D | SEG_E | SEG_F | SEG_G1,
    SEG_A | SEG_E | SEG_F | SEG_G1
  };

  typedef logic signed [COORD_W-1:0] coord_t;

  // Geometry derived from the glyph size register.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [BPR_W-1:0]  bpr;
    coord_t            thick;
    coord_t            xm;
    coord_t            xr;
    coord_t            yt;
    coord_t            yb;
    coord_t            ym;
    coord_t            up_end;
    coord_t            lo_start;
  } geom_t;

  // Row-stage result handed to the column stage.
  typedef struct packed {
    logic       valid;
    logic       outside;
    logic [3:0] col;
    logic       hbar;
    logic       vleft;
    logic       vright;
  } row_info_t;

  function automatic geom_t geom_calc(input logic [SIZE_W-1:0] raw);
    logic [SIZE_W-1:0] s;
    logic [15:0]       prod;
    logic [4:0]        d12;
    logic [5:0]        d6;
    geom_t             g;
    s    = (raw > SIZE_W'(MAX_GLYPH_SIZE)) ? SIZE_W'(MAX_GLYPH_SIZE) : raw;
    prod = 16'(s) * RECIP_12;
    d12  = prod[15:11];
    d6   = prod[15:10];
    g.size     = s;
    g.bpr      = BPR_W'((9'(s) + 9'd7) >> 3);
    g.thick    = (d12 < 5'd2) ? COORD_W'(2) : coord_t'({5'b0, d12});
    g.xm       = coord_t'({4'b0, d6});
    g.xr       = coord_t'({2'b0, s}) - coord_t'(1) - g.xm;
    g.yt       = coord_t'({5'b0, s[7:3]});
    g.yb       = coord_t'({2'b0, s}) - coord_t'(1) - g.yt;
    g.ym       = coord_t'({3'b0, s[7:1]}) - g.thick;
    g.up_end   = g.ym - coord_t'(1);
    g.lo_start = g.ym + g.thick + coord_t'(1);
    return g;
  endfunction

  function automatic logic [7:0] char_segs(input logic [7:0] code);
    logic [7:0] segs;
    segs = 8'h00;
    if (code >= 8'h30 && code <= 8'h39) begin
      segs = DIGIT_SEGS[4'(code - 8'h30)];
    end else if (code >= 8'h41 && code <= 8'h46) begin
      segs = DIGIT_SEGS[4'(code - 8'h41 + 8'd10)];
    end else if (code >= 8'h61 && code <= 8'h66) begin
      segs = DIGIT_SEGS[4'(code - 8'h61 + 8'd10)];
    end
    return segs;
  endfunction

  // Inclusive span test; reversed ends cover the same range.
  function automatic logic in_span(input coord_t v, input coord_t lo, input coord_t hi);
    return (v >= lo && v <= hi) || (v >= hi && v <= lo);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/seven_segment_glyph_rasterizer_core.sv
// Top level of the seven-segment glyph rasterizer: config port and three-stage pipeline.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       request    in_valid/in_stall    char_code, row_index, byte_column
// out_      result     out_valid/out_stall  pixel_byte, outside_glyph
// config    APB write  psel/penable/pwrite  glyph_size at byte address 0
//
// One request per cycle is sustained while out_stall does not hold the pipe.
// Stage 1 captures the request and decodes segments, stage 2 tests
// the row against each bar, stage 3 tests the eight pixel columns.
// The whole pipe advances together; it holds only while a result sits in the
// output register with out_stall high, and in_stall follows that condition.
// Reset (synchronous, rst_n low) empties the pipe and loads glyph size 48.

module seven_segment_glyph_rasterizer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [6:0]  in_row_index,
  input  wire logic [3:0]  in_byte_column,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_pixel_byte,
  output logic             out_outside_glyph,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  ssgr_pkg::geom_t     geom;
  ssgr_pkg::row_info_t row_info;
  logic                adv;
  logic                s1_valid;

  // Pipe moves when the output register is empty or being drained.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ssgr_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  ssgr_row u_row (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_char_code   (in_char_code),
    .in_row_index   (in_row_index),
    .in_byte_column (in_byte_column),
    .geom           (geom),
    .s1_valid       (s1_valid),
    .row_info       (row_info)
  );

  ssgr_col u_col (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .row_info          (row_info),
    .geom              (geom),
    .out_valid         (out_valid),
    .out_pixel_byte    (out_pixel_byte),
    .out_outside_glyph (out_outside_glyph)
  );

  // An accepted request lands in stage 1.
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted request missing from stage 1");

  // Out-of-glyph results always read all white.
  a_outside_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outside_glyph) |-> (out_pixel_byte == 8'hFF))
    else $error("outside_glyph result with non-white byte");

  // A zero-size glyph has no inside pixels.
  a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_outside_glyph) |-> (geom.size != 8'd0))
    else $error("inside result with zero glyph size");

endmodule

`default_nettype wire

FILE: hdl/ssgr_geom.sv
// Glyph size register, APB decode and derived segment geometry.
`default_nettype none

module ssgr_geom (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output ssgr_pkg::geom_t                   geom
);

  logic [ssgr_pkg::SIZE_W-1:0] size_r;
  ssgr_pkg::geom_t             geom_r;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == ssgr_pkg::REG_GLYPH_SIZE);

  // Geometry is worked out from the write data so it is ready with the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= ssgr_pkg::GLYPH_SIZE_RST;
      geom_r <= ssgr_pkg::geom_calc(ssgr_pkg::GLYPH_SIZE_RST);
    end else if (wr_en) begin
      size_r <= pwdata[7:0];
      geom_r <= ssgr_pkg::geom_calc(pwdata[7:0]);
    end
  end

  assign prdata = (paddr[2] == ssgr_pkg::REG_GLYPH_SIZE) ? {24'b0, size_r} : 32'b0;
  assign geom   = geom_r;

endmodule

`default_nettype wire

FILE: hdl/ssgr_row.sv
// Stages 1 and 2: request capture, segment decode and per-row bar hits.
`default_nettype none

module ssgr_row (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire logic [7:0]           in_char_code,
  input  wire logic [6:0]           in_row_index,
  input  wire logic [3:0]           in_byte_column,
  input  wire ssgr_pkg::geom_t      geom,
  output logic                      s1_valid,
  output ssgr_pkg::row_info_t       row_info
);

  logic                s1_valid_r;
  logic                s1_outside_r;
  logic [7:0]          s1_segs_r;
  logic [6:0]          s1_row_r;
  logic [3:0]          s1_col_r;
  ssgr_pkg::row_info_t s2_r;
  ssgr_pkg::row_info_t s2_nxt;
  ssgr_pkg::coord_t    y;
  logic                row_a;
  logic                row_d;
  logic                row_g1;
  logic                row_g2;
  logic                row_up;
  logic                row_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_outside_r <= ({1'b0, in_row_index} >= geom.size) ||
                      ({1'b0, in_byte_column} >= geom.bpr);
      s1_segs_r    <= ssgr_pkg::char_segs(in_char_code);
      s1_row_r     <= in_row_index;
      s1_col_r     <= in_byte_column;
    end
  end

  assign y = ssgr_pkg::coord_t'({3'b0, s1_row_r});

  always_comb begin
    row_a  = (y >= geom.yt) && (y < geom.yt + geom.thick);
    row_d  = (y >= geom.yb) && (y < geom.yb + geom.thick);
    row_g1 = (y >= geom.ym) && (y < geom.ym + geom.thick);
    row_g2 = (y >= geom.lo_start) && (y < geom.lo_start + geom.thick);
    row_up = ssgr_pkg::in_span(y, geom.yt, geom.up_end);
    row_lo = ssgr_pkg::in_span(y, geom.lo_start, geom.yb);

    s2_nxt.valid   = s1_valid_r;
    s2_nxt.outside = s1_outside_r;
    s2_nxt.col     = s1_col_r;
    s2_nxt.hbar    = (|(s1_segs_r & ssgr_pkg::SEG_A)  && row_a)  ||
                     (|(s1_segs_r & ssgr_pkg::SEG_D)  && row_d)  ||
                     (|(s1_segs_r & ssgr_pkg::SEG_G1) && row_g1) ||
                     (|(s1_segs_r & ssgr_pkg::SEG_G2) && row_g2);
    s2_nxt.vleft   = (|(s1_segs_r & ssgr_pkg::SEG_F) && row_up) ||
                     (|(s1_segs_r & ssgr_pkg::SEG_E) && row_lo);
    s2_nxt.vright  = (|(s1_segs_r & ssgr_pkg::SEG_B) && row_up) ||
                     (|(s1_segs_r & ssgr_pkg::SEG_C) && row_lo);
  end

  // Only the valid bit is cleared by reset; the rest just follows the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign row_info = s2_r;

endmodule

`default_nettype wire

FILE: hdl/ssgr_col.sv
// Stage 3: per-pixel column tests and the output register.
`default_nettype none

module ssgr_col (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire ssgr_pkg::row_info_t  row_info,
  input  wire ssgr_pkg::geom_t      geom,
  output logic                      out_valid,
  output logic [7:0]                out_pixel_byte,
  output logic                      out_outside_glyph
);

  logic             valid_r;
  logic [7:0]       byte_r;
  logic             outside_r;
  logic [7:0]       byte_nxt;
  ssgr_pkg::coord_t x [8];
  logic             black [8];

  // Bit 7 is the leftmost pixel of the byte.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      x[b] = ssgr_pkg::coord_t'({3'b0, row_info.col, 3'(b)});
      black[b] = (x[b] < ssgr_pkg::coord_t'({2'b0, geom.size})) && (
                 (row_info.hbar && ssgr_pkg::in_span(x[b], geom.xm, geom.xr)) ||
                 (row_info.vleft && x[b] >= geom.xm && x[b] < geom.xm + geom.thick) ||
                 (row_info.vright && x[b] >= geom.xr && x[b] < geom.xr + geom.thick));
      byte_nxt[7-b] = !black[b];
    end
    if (row_info.outside) begin
      byte_nxt = 8'hFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= row_info.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r    <= byte_nxt;
      outside_r <= row_info.outside;
    end
  end

  assign out_valid         = valid_r;
  assign out_pixel_byte    = byte_r;
  assign out_outside_glyph = outside_r;

endmodule

`default_nettype wire

FILE: tb/seven_segment_glyph_rasterizer_core_tb.sv
// Self-checking testbench for the seven-segment glyph rasterizer core.
module seven_segment_glyph_rasterizer_core_tb;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 16;
  localparam int          PHASE_ITEMS = 120;
  localparam int          IDLE_PCT    = 31;
  localparam int          SHOW_MAX    = 10;
  // Config byte addresses: the size register and an unmapped word.
  localparam logic [2:0]  GLYPH_SIZE_ADDR = 3'd0;
  localparam logic [2:0]  SPARE_ADDR      = 3'd4;
  // First codes of the recognized character ranges.
  localparam logic [7:0]  CH_ZERO    = "0";
  localparam logic [7:0]  CH_UPPER_A = "A";
  localparam logic [7:0]  CH_LOWER_A = "a";

  typedef struct packed {
    logic [7:0] pix;
    logic       outside;
  } glyph_byte_t;

  // Tracks the size register, predicts each glyph byte and checks results in order.
  class glyph_scoreboard;
    glyph_byte_t expected_q[$];
    int unsigned size_reg;
    int unsigned errors;

    function new();
      size_reg = 48;
      errors   = 0;
    endfunction

    function void set_size(logic [7:0] v);
      size_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] segments_for(logic [7:0] code);
      int d;
      d = -1;
      if (code >= CH_ZERO && code <= CH_ZERO + 8'd9) d = code - CH_ZERO;
      else if (code >= CH_UPPER_A && code <= CH_UPPER_A + 8'd5) d = code - CH_UPPER_A + 10;
      else if (code >= CH_LOWER_A && code <= CH_LOWER_A + 8'd5) d = code - CH_LOWER_A + 10;
      case (d)
        0:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D |
                   ssgr_pkg::SEG_E | ssgr_pkg::SEG_F;
        1:  return ssgr_pkg::SEG_B | ssgr_pkg::SEG_C;
        2:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_B | ssgr_pkg::SEG_D | ssgr_pkg::SEG_E |
                   ssgr_pkg::SEG_G1;
        3:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D |
                   ssgr_pkg::SEG_G1;
        4:  return ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_F | ssgr_pkg::SEG_G1;
        5:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D | ssgr_pkg::SEG_F |
                   ssgr_pkg::SEG_G1;
        6:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D | ssgr_pkg::SEG_E |
                   ssgr_pkg::SEG_F | ssgr_pkg::SEG_G1;
        7:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_B | ssgr_pkg::SEG_C;
        8:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D |
                   ssgr_pkg::SEG_E | ssgr_pkg::SEG_F | ssgr_pkg::SEG_G1;
        9:  return ssgr_pkg::SEG_A | ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D |
                   ssgr_pkg::SEG_F | ssgr_pkg::SEG_G1;
        10: return ssgr_pkg::SEG_A | ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_E |
                   ssgr_pkg::SEG_F | ssgr_pkg::SEG_G1;
        11: return ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D | ssgr_pkg::SEG_E |
                   ssgr_pkg::SEG_F | ssgr_pkg::SEG_G1;
        12: return ssgr_pkg::SEG_A | ssgr_pkg::SEG_D | ssgr_pkg::SEG_E | ssgr_pkg::SEG_F;
        13: return ssgr_pkg::SEG_B | ssgr_pkg::SEG_C | ssgr_pkg::SEG_D | ssgr_pkg::SEG_E |
                   ssgr_pkg::SEG_G1;
        14: return ssgr_pkg::SEG_A | ssgr_pkg::SEG_D | ssgr_pkg::SEG_E | ssgr_pkg::SEG_F |
                   ssgr_pkg::SEG_G1;
        15: return ssgr_pkg::SEG_A | ssgr_pkg::SEG_E | ssgr_pkg::SEG_F | ssgr_pkg::SEG_G1;
        default: return 8'h00;
      endcase
    endfunction

    // Inclusive range, ends in either order.
    function bit covers(int v, int a, int b);
      return (v >= a && v <= b) || (v >= b && v <= a);
    endfunction

    function bit pixel_dark(logic [7:0] segs, int s, int x, int y);
      int th, xm, xr, yt, yb, ym, up_end, lo_start;
      bit hit;
      th = s / 12;
      if (th < 2) th = 2;
      xm       = s / 6;
      xr       = s - 1 - xm;
      yt       = s / 8;
      yb       = s - 1 - yt;
      ym       = s / 2 - th;
      up_end   = ym - 1;
      lo_start = ym + th + 1;
      hit = 0;
      // horizontal bars: top, bottom, two middle bands
      if ((segs & ssgr_pkg::SEG_A) != 0 && covers(x, xm, xr) && y >= yt && y < yt + th)
        hit = 1;
      if ((segs & ssgr_pkg::SEG_D) != 0 && covers(x, xm, xr) && y >= yb && y < yb + th)
        hit = 1;
      if ((segs & ssgr_pkg::SEG_G1) != 0 && covers(x, xm, xr) && y >= ym && y < ym + th)
        hit = 1;
      if ((segs & ssgr_pkg::SEG_G2) != 0 && covers(x, xm, xr) &&
          y >= lo_start && y < lo_start + th)
        hit = 1;
      // vertical bars: upper and lower halves, left and right
      if ((segs & ssgr_pkg::SEG_F) != 0 && covers(y, yt, up_end) && x >= xm && x < xm + th)
        hit = 1;
      if ((segs & ssgr_pkg::SEG_B) != 0 && covers(y, yt, up_end) && x >= xr && x < xr + th)
        hit = 1;
      if ((segs & ssgr_pkg::SEG_E) != 0 && covers(y, lo_start, yb) && x >= xm && x < xm + th)
        hit = 1;
      if ((segs & ssgr_pkg::SEG_C) != 0 && covers(y, lo_start, yb) && x >= xr && x < xr + th)
        hit = 1;
      return hit;
    endfunction

    function void note_request(logic [7:0] code, logic [6:0] row, logic [3:0] col);
      glyph_byte_t e;
      int s, r, c, x;
      logic [7:0] segs;
      s = (size_reg > ssgr_pkg::MAX_GLYPH_SIZE) ? ssgr_pkg::MAX_GLYPH_SIZE : size_reg;
      r = row;
      c = col;
      if (r >= s || c >= (s + 7) / 8) begin
        e.pix     = 8'hFF;
        e.outside = 1'b1;
      end else begin
        segs      = segments_for(code);
        e.outside = 1'b0;
        for (int b = 0; b < 8; b++) begin
          x = c * 8 + b;
          // padding past the glyph edge reads white
          e.pix[7-b] = !((x < s) && pixel_dark(segs, s, x, r));
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [7:0] pix, logic outside);
      glyph_byte_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("unexpected result: pixel_byte %h outside_glyph %b", pix, outside);
        return;
      end
      e = expected_q.pop_front();
      if (pix !== e.pix || outside !== e.outside) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("mismatch: pixel_byte exp %h got %h, outside_glyph exp %b got %b",
                   e.pix, pix, e.outside, outside);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic [6:0]  in_row_index;
  logic [3:0]  in_byte_column;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_pixel_byte;
  logic        out_outside_glyph;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  glyph_scoreboard sb;
  int unsigned     cycles;
  // When set, neither side inserts gaps or stalls.
  logic            calm;

  seven_segment_glyph_rasterizer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_row_index      (in_row_index),
    .in_byte_column    (in_byte_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_byte    (out_pixel_byte),
    .out_outside_glyph (out_outside_glyph),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check what was accepted at this edge, then pick the next stall.
  // Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pixel_byte, out_outside_glyph);
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Present one request, with optional leading gap cycles, and hold it until taken.
  // in_valid is left high afterwards so back-to-back requests need one assignment.
  task automatic send_request(input logic [7:0] code, input logic [6:0] row,
                              input logic [3:0] col);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= code;
    in_row_index   <= row;
    in_byte_column <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(code, row, col);
  endtask

  // Mostly in-glyph requests for recognized characters, the rest raw noise.
  task automatic random_request(input int s);
    int eff, bpr;
    logic [7:0] code;
    logic [6:0] row;
    logic [3:0] col;
    eff  = (s > ssgr_pkg::MAX_GLYPH_SIZE) ? ssgr_pkg::MAX_GLYPH_SIZE : s;
    bpr  = (eff + 7) / 8;
    code = 8'($urandom);
    row  = 7'($urandom);
    col  = 4'($urandom);
    if (eff > 0 && $urandom_range(99) < 80) begin
      row = 7'($urandom_range(eff - 1));
      col = 4'($urandom_range(bpr - 1));
      case ($urandom_range(3))
        0: begin
          code = 8'(CH_ZERO + $urandom_range(9));
        end
        1: begin
          code = 8'(CH_UPPER_A + $urandom_range(5));
        end
        2: begin
          code = 8'(CH_LOWER_A + $urandom_range(5));
        end
        default: begin
        end
      endcase
    end
    send_request(code, row, col);
  endtask

  // Drop valid and wait for every outstanding request to come back.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == GLYPH_SIZE_ADDR) sb.set_size(data[7:0]);
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase_size [PHASES];

    sb = new();
    rst_n          <= 1'b0;
    calm           <= 1'b0;
    cycles         <= 0;
    in_valid       <= 1'b0;
    in_char_code   <= 8'h00;
    in_row_index   <= 7'h00;
    in_byte_column <= 4'h0;
    out_stall      <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= GLYPH_SIZE_ADDR;
    pwdata         <= 32'h0;

    // Sizes cover the legal extremes, zero, saturation above the max,
    // tiny glyphs where clipping matters, and odd widths with padding bits.
    phase_size = '{12, 128, 0, 255, 24, 1, 5, 11, 96, 129, 60, 36, 2, 7, 0, 0};
    phase_size[14] = $urandom_range(12, 128);
    phase_size[15] = $urandom_range(255);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset size of 48 (six bytes per row).
    send_request("0", 7'd0,   4'd0);
    send_request("1", 7'd6,   4'd1);
    send_request("2", 7'd20,  4'd2);
    send_request("3", 7'd47,  4'd5);
    send_request("4", 7'd10,  4'd4);
    send_request("5", 7'd24,  4'd1);
    send_request("6", 7'd30,  4'd0);
    send_request("7", 7'd7,   4'd3);
    send_request("8", 7'd22,  4'd4);
    send_request("9", 7'd41,  4'd2);
    send_request("A", 7'd26,  4'd1);
    send_request("B", 7'd35,  4'd4);
    send_request("C", 7'd42,  4'd3);
    send_request("D", 7'd12,  4'd1);
    send_request("E", 7'd23,  4'd2);
    send_request("F", 7'd27,  4'd0);
    send_request("a", 7'd8,   4'd2);
    send_request("f", 7'd25,  4'd4);
    // just outside the recognized ranges: blank glyph
    send_request("/", 7'd6,   4'd2);
    send_request(":", 7'd7,   4'd2);
    send_request("@", 7'd22,  4'd3);
    send_request("g", 7'd41,  4'd1);
    // row and byte beyond the glyph, then both at their field maximum
    send_request("8", 7'd48,  4'd0);
    send_request(8'hFF, 7'd0, 4'd6);
    send_request(8'h00, 7'd127, 4'd15);
    drain_pipe();

    for (int p = 0; p < PHASES; p++) begin
      // upper data bits are junk; only the low byte belongs to the register
      write_reg(GLYPH_SIZE_ADDR,
                {16'($urandom_range(16'hFFFF)), 8'h00, 8'(phase_size[p])});
      // a write to the unmapped word must leave the size alone
      if (p == 4) write_reg(SPARE_ADDR, 32'd12);
      calm <= (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off mid-phase until the pipe is empty
        if (p == 8 && i == 60) begin
          drain_pipe();
          repeat (3) @(posedge clk);
        end
        random_request(phase_size[p]);
      end
      drain_pipe();
    end

    calm <= 1'b0;
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
